// ===== hdl/input_event_to_hid_report_defines.svh =====
// Assertion macros for the event-to-report translator.
// Depends on nothing; included by the top level.
`ifndef INPUT_EVENT_TO_HID_REPORT_DEFINES_SVH
`define INPUT_EVENT_TO_HID_REPORT_DEFINES_SVH
`ifndef SYNTH
`define EHR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EHR_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EHR_ASSERT(label, clk, rst, prop, msg)
`define EHR_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hdl/ehr_pkg.sv =====
// Shared types, constants and tables of the event-to-report translator.
// No dependencies.
`default_nettype none
package ehr_pkg;
   localparam int MAX_TRACKED_KEYS = 16;
   localparam int REPORT_KEY_SLOTS = 6;
   localparam int MAX_MOUSE_REPORTS = 63;
   localparam int KEY_IDX_W = $clog2(MAX_TRACKED_KEYS);
   localparam int KEY_CNT_W = $clog2(MAX_TRACKED_KEYS + 1);
   localparam int ACC_W = 14;
   localparam logic signed [ACC_W-1:0] ACC_LIMIT = ACC_W'(127 * MAX_MOUSE_REPORTS);
   localparam logic signed [ACC_W-1:0] CHUNK_MAX = ACC_W'(127);

   localparam logic [1:0] OP_EVENT = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_CLEAR_REL = 2'd2;

   localparam logic [15:0] EV_SYN = 16'd0;
   localparam logic [15:0] EV_KEY = 16'd1;
   localparam logic [15:0] EV_REL = 16'd2;

   localparam logic [1:0] CSR_ENABLE = 2'd0;
   localparam logic [1:0] CSR_KBD_ID = 2'd1;
   localparam logic [1:0] CSR_MOUSE_ID = 2'd2;

   // classified command kinds between front and back
   localparam logic [2:0] CMD_KEY = 3'd0;
   localparam logic [2:0] CMD_REL = 3'd1;
   localparam logic [2:0] CMD_SYNC = 3'd2;
   localparam logic [2:0] CMD_CLEAR = 3'd3;
   localparam logic [2:0] CMD_CLEAR_REL = 3'd4;
   localparam logic [2:0] CMD_NONE = 3'd5;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] event_type;
      logic [15:0] event_code;
      logic signed [31:0] event_value;
   } req_type;

   typedef struct packed {
      logic        report_kind;
      logic [7:0]  report_id;
      logic [7:0]  state_bits;
      logic [47:0] key_array;
      logic signed [7:0] move_x;
      logic signed [7:0] move_y;
      logic signed [7:0] wheel_step;
      logic        last_report;
   } rsp_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       down;
      logic [7:0] usage;     // mapped key usage, 0 if none
      logic [7:0] modifier;  // modifier bit
      logic [4:0] button;    // button bit
      logic [1:0] axis;      // 0 x, 1 y, 2 wheel, 3 other
      logic signed [31:0] value;
      logic       nonzero;
   } cmd_type;

   function automatic logic [7:0] usage_of_code(input logic [6:0] c);
      logic [7:0] u;
      unique case (c)
         7'd1: u = 8'h29; 7'd2: u = 8'h1E; 7'd3: u = 8'h1F; 7'd4: u = 8'h20;
         7'd5: u = 8'h21; 7'd6: u = 8'h22; 7'd7: u = 8'h23; 7'd8: u = 8'h24;
         7'd9: u = 8'h25; 7'd10: u = 8'h26; 7'd11: u = 8'h27; 7'd12: u = 8'h2D;
         7'd13: u = 8'h2E; 7'd14: u = 8'h2A; 7'd15: u = 8'h2B; 7'd16: u = 8'h14;
         7'd17: u = 8'h1A; 7'd18: u = 8'h08; 7'd19: u = 8'h15; 7'd20: u = 8'h17;
         7'd21: u = 8'h1C; 7'd22: u = 8'h18; 7'd23: u = 8'h0C; 7'd24: u = 8'h12;
         7'd25: u = 8'h13; 7'd26: u = 8'h2F; 7'd27: u = 8'h30; 7'd28: u = 8'h28;
         7'd30: u = 8'h04; 7'd31: u = 8'h16; 7'd32: u = 8'h07; 7'd33: u = 8'h09;
         7'd34: u = 8'h0A; 7'd35: u = 8'h0B; 7'd36: u = 8'h0D; 7'd37: u = 8'h0E;
         7'd38: u = 8'h0F; 7'd39: u = 8'h33; 7'd40: u = 8'h34; 7'd41: u = 8'h35;
         7'd43: u = 8'h31; 7'd44: u = 8'h1D; 7'd45: u = 8'h1B; 7'd46: u = 8'h06;
         7'd47: u = 8'h19; 7'd48: u = 8'h05; 7'd49: u = 8'h11; 7'd50: u = 8'h10;
         7'd51: u = 8'h36; 7'd52: u = 8'h37; 7'd53: u = 8'h38; 7'd57: u = 8'h2C;
         7'd58: u = 8'h39; 7'd59: u = 8'h3A; 7'd60: u = 8'h3B; 7'd61: u = 8'h3C;
         7'd62: u = 8'h3D; 7'd63: u = 8'h3E; 7'd64: u = 8'h3F; 7'd65: u = 8'h40;
         7'd66: u = 8'h41; 7'd67: u = 8'h42; 7'd68: u = 8'h43; 7'd69: u = 8'h53;
         7'd70: u = 8'h47; 7'd87: u = 8'h44; 7'd88: u = 8'h45; 7'd102: u = 8'h4A;
         7'd103: u = 8'h52; 7'd104: u = 8'h4B; 7'd105: u = 8'h50; 7'd106: u = 8'h4F;
         7'd107: u = 8'h4D; 7'd108: u = 8'h51; 7'd109: u = 8'h4E; 7'd110: u = 8'h49;
         7'd111: u = 8'h4C;
         default: u = 8'h00;
      endcase
      return u;
   endfunction

   function automatic logic [7:0] modifier_of_code(input logic [15:0] c);
      logic [7:0] m;
      unique case (c)
         16'd29: m = 8'h01; 16'd42: m = 8'h02; 16'd56: m = 8'h04; 16'd125: m = 8'h08;
         16'd97: m = 8'h10; 16'd54: m = 8'h20; 16'd100: m = 8'h40; 16'd126: m = 8'h80;
         default: m = 8'h00;
      endcase
      return m;
   endfunction
endpackage
`default_nettype wire

// ===== hdl/ehr_front.sv =====
// Front end: accepts requests and classifies them into commands.
// Depends on ehr_pkg.
`default_nettype none
module ehr_front import ehr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire req_type in_req,
   output logic         in_ready,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  wire logic    cmd_ready
);
   // two-entry queue
   cmd_type    q_ff [2];
   cmd_type    q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;
   logic [7:0] mod;
   logic       is_btn;

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd = q_ff[rd_ff];

   always_comb begin
      mod = modifier_of_code(in_req.event_code);
      is_btn = (in_req.event_code >= 16'h110) && (in_req.event_code <= 16'h114);
      q_in = '0;
      q_in.kind = CMD_NONE;
      q_in.down = (in_req.event_value != 32'sd0);
      q_in.nonzero = (in_req.event_value != 32'sd0);
      q_in.value = in_req.event_value;
      q_in.axis = 2'd3;
      unique case (in_req.op)
         OP_CLEAR: q_in.kind = CMD_CLEAR;
         OP_CLEAR_REL: q_in.kind = CMD_CLEAR_REL;
         OP_EVENT: begin
            unique case (in_req.event_type)
               EV_KEY: begin
                  q_in.kind = CMD_KEY;
                  if (is_btn) q_in.button = 5'(5'd1 << in_req.event_code[2:0]);
                  else if (mod != 8'h00) q_in.modifier = mod;
                  else if (in_req.event_code < 16'd128)
                     q_in.usage = usage_of_code(in_req.event_code[6:0]);
               end
               EV_REL: begin
                  q_in.kind = CMD_REL;
                  if (in_req.event_code == 16'd0) q_in.axis = 2'd0;
                  else if (in_req.event_code == 16'd1) q_in.axis = 2'd1;
                  else if (in_req.event_code == 16'd8) q_in.axis = 2'd2;
               end
               EV_SYN: if (in_req.event_code == 16'd0) q_in.kind = CMD_SYNC;
               default: q_in.kind = CMD_NONE;
            endcase
         end
         default: q_in.kind = CMD_NONE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      rd_in = rd_ff ^ pop;
      wr_in = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) q_ff[wr_ff] <= q_in;
   end
endmodule
`default_nettype wire

// ===== hdl/ehr_back.sv =====
// Back end: applies commands to the key list and accumulators, emits reports.
// Depends on ehr_pkg.
`default_nettype none
module ehr_back import ehr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_ready,
   input  wire logic [1:0] enable_mask,
   input  wire logic [7:0] kbd_id,
   input  wire logic [7:0] mouse_id,
   output logic         out_valid,
   output rsp_type      out_rsp,
   input  wire logic    out_ready,
   output logic         busy
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SRCH  = 3'd1;
   localparam logic [2:0] ST_SHIFT = 3'd2;
   localparam logic [2:0] ST_KBD   = 3'd3;
   localparam logic [2:0] ST_MOUSE = 3'd4;

   logic [2:0] st_ff, st_in;
   cmd_type    c_ff, c_in;
   logic [7:0] keys_ff [MAX_TRACKED_KEYS];
   logic [KEY_CNT_W-1:0] cnt_ff, cnt_in;
   logic [KEY_CNT_W-1:0] i_ff, i_in;
   logic [7:0] mod_ff, mod_in;
   logic       kch_ff, kch_in, mch_ff, mch_in;
   logic [4:0] btn_ff, btn_in;
   logic signed [ACC_W-1:0] px_ff, px_in, py_ff, py_in, pw_ff, pw_in;
   logic [5:0] nm_ff, nm_in;   // mouse reports emitted this command
   logic       mouse_after_ff, mouse_after_in;
   logic       ov_ff, ov_in;
   rsp_type    o_ff, o_in;
   logic       key_wr;
   logic [KEY_IDX_W-1:0] key_wa;
   logic [7:0] key_wd;
   logic signed [ACC_W-1:0] cx, cy, cw, rx, ry, rw, acc_sel, acc_sum;
   logic signed [33:0] wide;
   logic [47:0] karr;
   logic       more;

   function automatic logic signed [ACC_W-1:0] chunk(input logic signed [ACC_W-1:0] v);
      if (v > CHUNK_MAX) return CHUNK_MAX;
      else if (v < -CHUNK_MAX) return -CHUNK_MAX;
      else return v;
   endfunction

   assign busy = (st_ff != ST_IDLE) || ov_ff;
   assign out_valid = ov_ff;
   assign out_rsp = o_ff;
   assign cmd_ready = (st_ff == ST_IDLE) && !ov_ff;

   always_comb begin
      karr = '0;
      for (int s = 0; s < REPORT_KEY_SLOTS; s++)
         if (KEY_CNT_W'(s) < cnt_ff) karr[8*s +: 8] = keys_ff[s];
      cx = chunk(px_ff); cy = chunk(py_ff); cw = chunk(pw_ff);
      rx = px_ff - cx; ry = py_ff - cy; rw = pw_ff - cw;
      unique case (c_ff.axis)
         2'd0: acc_sel = px_ff;
         2'd1: acc_sel = py_ff;
         default: acc_sel = pw_ff;
      endcase
      wide = 34'(acc_sel) + 34'(c_ff.value);
      if (wide > 34'(ACC_LIMIT)) acc_sum = ACC_LIMIT;
      else if (wide < -34'(ACC_LIMIT)) acc_sum = -ACC_LIMIT;
      else acc_sum = ACC_W'(wide);
      more = (rx != 0 || ry != 0 || rw != 0) && (nm_ff != 6'(MAX_MOUSE_REPORTS - 1));
   end

   always_comb begin
      st_in = st_ff; c_in = c_ff; cnt_in = cnt_ff; i_in = i_ff;
      mod_in = mod_ff; kch_in = kch_ff; mch_in = mch_ff; btn_in = btn_ff;
      px_in = px_ff; py_in = py_ff; pw_in = pw_ff; nm_in = nm_ff;
      mouse_after_in = mouse_after_ff; ov_in = ov_ff; o_in = o_ff;
      key_wr = 1'b0; key_wa = '0; key_wd = c_ff.usage;
      if (ov_ff && out_ready) ov_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: if (cmd_valid && cmd_ready) begin
            c_in = cmd;
            i_in = '0;
            nm_in = '0;
            unique case (cmd.kind)
               CMD_KEY: begin
                  if (cmd.button != 5'd0) begin
                     if ((cmd.down ? (btn_ff | cmd.button) : (btn_ff & ~cmd.button)) != btn_ff)
                        mch_in = 1'b1;
                     btn_in = cmd.down ? (btn_ff | cmd.button) : (btn_ff & ~cmd.button);
                  end else if (cmd.modifier != 8'h00) begin
                     if ((cmd.down ? (mod_ff | cmd.modifier) : (mod_ff & ~cmd.modifier)) != mod_ff)
                        kch_in = 1'b1;
                     mod_in = cmd.down ? (mod_ff | cmd.modifier) : (mod_ff & ~cmd.modifier);
                  end else if (cmd.usage != 8'h00) st_in = ST_SRCH;
               end
               CMD_REL: st_in = ST_SRCH; // the add happens in ST_SRCH
               CMD_SYNC: begin
                  if (kch_ff && enable_mask[0]) st_in = ST_KBD;
                  else st_in = ST_MOUSE;
                  kch_in = 1'b0;
                  mouse_after_in = 1'b1;
               end
               CMD_CLEAR, CMD_CLEAR_REL: begin
                  mod_in = '0; cnt_in = '0; kch_in = 1'b0; btn_in = '0;
                  px_in = '0; py_in = '0; pw_in = '0; mch_in = 1'b0;
                  if (cmd.kind == CMD_CLEAR_REL) begin
                     mouse_after_in = enable_mask[1];
                     mch_in = enable_mask[1];
                     if (enable_mask[0]) st_in = ST_KBD;
                     else if (enable_mask[1]) st_in = ST_MOUSE;
                  end
               end
               default: st_in = ST_IDLE;
            endcase
         end
         ST_SRCH: begin
            if (c_ff.kind == CMD_REL) begin
               if (c_ff.axis == 2'd0) px_in = acc_sum;
               else if (c_ff.axis == 2'd1) py_in = acc_sum;
               else if (c_ff.axis == 2'd2) pw_in = acc_sum;
               if (c_ff.nonzero) mch_in = 1'b1;
               st_in = ST_IDLE;
            end else if (i_ff < cnt_ff) begin
               if (keys_ff[i_ff[KEY_IDX_W-1:0]] == c_ff.usage) begin
                  if (c_ff.down) st_in = ST_IDLE;
                  else begin
                     i_in = i_ff + 1'b1;
                     st_in = ST_SHIFT;
                  end
               end else i_in = i_ff + 1'b1;
            end else begin
               if (c_ff.down && cnt_ff < KEY_CNT_W'(MAX_TRACKED_KEYS)) begin
                  key_wr = 1'b1;
                  key_wa = cnt_ff[KEY_IDX_W-1:0];
                  cnt_in = cnt_ff + 1'b1;
                  kch_in = 1'b1;
               end
               st_in = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            // move entry i down by one
            if (i_ff < cnt_ff) begin
               key_wa = KEY_IDX_W'(i_ff - 1'b1);
               key_wd = keys_ff[i_ff[KEY_IDX_W-1:0]];
               key_wr = 1'b1;
               i_in = i_ff + 1'b1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               kch_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         ST_KBD: if (!ov_ff || out_ready) begin
            o_in = '0;
            o_in.report_id = kbd_id;
            o_in.state_bits = mod_ff;
            o_in.key_array = karr;
            ov_in = 1'b1;
            if (mouse_after_ff && enable_mask[1] &&
                (mch_ff || px_ff != 0 || py_ff != 0 || pw_ff != 0))
               st_in = ST_MOUSE;
            else if (mouse_after_ff && !enable_mask[1]) begin
               mch_in = 1'b0; px_in = '0; py_in = '0; pw_in = '0;
               o_in.last_report = 1'b1;
               st_in = ST_IDLE;
            end else begin
               o_in.last_report = 1'b1;
               st_in = ST_IDLE;
            end
         end
         ST_MOUSE: begin
            if (!enable_mask[1]) begin
               mch_in = 1'b0; px_in = '0; py_in = '0; pw_in = '0;
               st_in = ST_IDLE;
            end else if (!mch_ff && px_ff == 0 && py_ff == 0 && pw_ff == 0) begin
               st_in = ST_IDLE;
            end else if (!ov_ff || out_ready) begin
               o_in = '0;
               o_in.report_kind = 1'b1;
               o_in.report_id = mouse_id;
               o_in.state_bits = {3'b000, btn_ff};
               o_in.move_x = 8'(cx);
               o_in.move_y = 8'(cy);
               o_in.wheel_step = 8'(cw);
               o_in.last_report = !more;
               ov_in = 1'b1;
               px_in = rx; py_in = ry; pw_in = rw;
               mch_in = 1'b0;
               nm_in = nm_ff + 1'b1;
               if (!more) st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // key list store
   always_ff @(posedge clock) begin
      if (key_wr) keys_ff[key_wa] <= key_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         cnt_ff <= '0;
         mod_ff <= '0;
         kch_ff <= 1'b0;
         mch_ff <= 1'b0;
         btn_ff <= '0;
         px_ff <= '0; py_ff <= '0; pw_ff <= '0;
         ov_ff <= 1'b0;
         mouse_after_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         mod_ff <= mod_in;
         kch_ff <= kch_in;
         mch_ff <= mch_in;
         btn_ff <= btn_in;
         px_ff <= px_in; py_ff <= py_in; pw_ff <= pw_in;
         ov_ff <= ov_in;
         mouse_after_ff <= mouse_after_in;
      end
      c_ff <= c_in;
      i_ff <= i_in;
      nm_ff <= nm_in;
      o_ff <= o_in;
   end
endmodule
`default_nettype wire

// ===== hdl/ehr_csr.sv =====
// Configuration registers behind the APB-style port.
// Depends on ehr_pkg.
`default_nettype none
module ehr_csr import ehr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic [1:0]       enable_mask,
   output logic [7:0]       kbd_id,
   output logic [7:0]       mouse_id
);
   logic [1:0] en_ff;
   logic [7:0] kid_ff, mid_ff;
   logic       wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;
   assign enable_mask = en_ff;
   assign kbd_id = kid_ff;
   assign mouse_id = mid_ff;

   always_comb begin
      unique case (paddr[3:2])
         CSR_ENABLE:   prdata = {30'd0, en_ff};
         CSR_KBD_ID:   prdata = {24'd0, kid_ff};
         CSR_MOUSE_ID: prdata = {24'd0, mid_ff};
         default:      prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 2'd3;
         kid_ff <= 8'd1;
         mid_ff <= 8'd2;
      end else if (wr) begin
         unique case (paddr[3:2])
            CSR_ENABLE:   en_ff <= pwdata[1:0];
            CSR_KBD_ID:   kid_ff <= pwdata[7:0];
            CSR_MOUSE_ID: mid_ff <= pwdata[7:0];
            default:      en_ff <= en_ff;
         endcase
      end
   end
   logic [1:0] unused_a;
   assign unused_a = paddr[1:0];
endmodule
`default_nettype wire

// ===== hdl/input_event_to_hid_report.sv =====
// Input event to keyboard/mouse report translator, top level.
// Flow: the back end takes a queued request only while idle with no report waiting. Key
// requests that reach the key list hold the back end for a list search, then a removal
// shift on release; relative ones for an accumulate step. A sync gives one report a cycle
// (up to 64) while pop keeps up. The back end sequencer sets rate.
// Reset (synchronous, high): empties queues, clears key/mouse state, registers to 3/1/2.
`default_nettype none
`include "input_event_to_hid_report_defines.svh"
module input_event_to_hid_report import ehr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire req_type     req_data,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic       in_ready, cmd_valid, cmd_ready, out_valid, busy;
   cmd_type    cmd;
   logic [1:0] en;
   logic [7:0] kid, mid;

   assign req_full = !in_ready;
   assign rsp_empty = !out_valid;

   // classify and queue requests
   ehr_front u_front (
      .clock, .reset, .in_valid(req_push), .in_req(req_data), .in_ready,
      .cmd_valid, .cmd, .cmd_ready);

   // state update and report sequencing
   ehr_back u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_ready,
      .enable_mask(en), .kbd_id(kid), .mouse_id(mid),
      .out_valid, .out_rsp(rsp_data), .out_ready(rsp_pop), .busy);

   ehr_csr u_csr (
      .clock, .reset, .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata), .pready(csr_pready),
      .enable_mask(en), .kbd_id(kid), .mouse_id(mid));

   // mouse report x chunks never fall outside the clamp
   `EHR_ASSERT(a_chunk, clock, reset, (!rsp_empty && rsp_data.report_kind) |-> (rsp_data.move_x != -8'sd128), "mouse chunk out of range")
   // keyboard reports carry no x motion and no wheel step
   `EHR_ASSERT(a_kbd_zero, clock, reset, (!rsp_empty && !rsp_data.report_kind) |-> (rsp_data.move_x == 8'sd0 && rsp_data.wheel_step == 8'sd0), "motion in keyboard report")
   // a waiting report holds until popped
   `EHR_ASSERT(a_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)), "report changed before pop")
endmodule
`default_nettype wire
